FILE: src/dcls_pkg.sv
// Shared types and constants for the divisor-count linear sieve unit.
// Depends on nothing; dcls_rem_unit and the top-level unit import it.
`default_nettype none

package dcls_pkg;

    // Field widths fixed by the word format.
    localparam int NUM_W   = 17;
    localparam int COUNT_W = 8;
    localparam int EXP_W   = 5;
    localparam int EPOCH_W = 8;

    localparam int unsigned NUM_MAX = (1 << NUM_W) - 1;

    // Saturation points and fixed values of the divisor arithmetic.
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
    localparam logic [EXP_W-1:0]   EXP_MAX     = 5'd31;
    localparam logic [EXP_W-1:0]   PRIME_EXP   = 5'd2;
    localparam logic [COUNT_W-1:0] PRIME_PART  = 8'd1;
    localparam logic [COUNT_W-1:0] ONE_COUNT   = 8'd1;
    localparam logic [NUM_W-1:0]   LIMIT_MIN   = 17'd2;
    localparam logic [NUM_W-1:0]   LIMIT_RESET = 17'h10000;

    // Epoch zero marks a cleared entry; live epochs run from one to the last code.
    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // One entry of the sieve store: composite tag, smallest prime factor and
    // the divisor data of the number at that address.
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [NUM_W-1:0]   spf;
        logic [COUNT_W-1:0] part;
        logic [EXP_W-1:0]   exp1;
    } sieve_entry_t;

    // Status of the iterative remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
        logic divisible;
    } rem_status_t;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_CHECK    = 7'b0000010,
        ST_WALK_MUL = 7'b0000100,
        ST_WALK_WR  = 7'b0001000,
        ST_WALK_DIV = 7'b0010000,
        ST_FINISH   = 7'b0100000,
        ST_CLEAR    = 7'b1000000
    } seq_state_t;

    // Product of partial count and exponent, saturated to the count width.
    function automatic logic [COUNT_W-1:0] sat_count(
        input logic [COUNT_W-1:0] part,
        input logic [EXP_W-1:0]   exp1
    );
        logic [COUNT_W+EXP_W-1:0] prod;
        prod = part * exp1;
        if (prod > {{EXP_W{1'b0}}, COUNT_MAX})
            return COUNT_MAX;
        else
            return prod[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/dcls_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the sieve store and the prime list.
`default_nettype none

module dcls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port; a read at the address being written returns old data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/dcls_rem_unit.sv
// Bit-serial restoring remainder unit that tells whether divisor divides dividend.
// Depends on dcls_pkg for the number width and the status struct.
`default_nettype none

module dcls_rem_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dcls_pkg::NUM_W-1:0] dividend,
    input  wire logic [dcls_pkg::NUM_W-1:0] divisor,
    output dcls_pkg::rem_status_t           status
);

    import dcls_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] shift_reg;
    logic [NUM_W-1:0] dvs_reg;

    logic [NUM_W:0]   trial;
    logic [NUM_W:0]   diff;
    logic             trial_ge;
    logic [NUM_W-1:0] rem_next;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, shift_reg[NUM_W-1]};
        trial_ge = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        rem_next = trial_ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
    end

    // Control: count the steps, flag completion for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and the dividend bits still to come.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            shift_reg <= dividend;
            dvs_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[NUM_W-2:0], 1'b0};
        end
    end

    assign status.busy      = busy_reg;
    assign status.done      = done_reg;
    assign status.divisible = (rem_reg == '0);

endmodule

`default_nettype wire

FILE: src/divisor_count_linear_sieve_unit.sv
// Divisor-count linear sieve unit: each input word advances to the next integer
// (or restarts at 1) and returns one word with the number, its divisor count and
// flags. An advance walks the primes up to the smallest prime factor of the
// number, stopping at the first prime whose multiple lies beyond the limit;
// number 1 and an exhausted word walk no primes. Each walked prime costs one
// prime-list read with a multiply and one write of the sieve store. After a
// limit write in the middle of a run, every walked prime also runs a bit-serial
// divisibility test until the next restart. After reset the whole sieve store
// is swept before the first word is taken, and every 255th restart repeats that
// sweep before its result. Limit writes take effect at once; the user must make
// them only while the unit is idle, which the block itself does not enforce.
// Depends on dcls_pkg, dcls_ram and dcls_rem_unit.
`default_nettype none

module divisor_count_linear_sieve_unit #(
    parameter int MAX_VALUE      = 65536,
    parameter int PRIME_CAPACITY = 8192
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // Configuration: the upper limit register.
    input  wire logic                         cfg_wr_en,
    input  wire logic [dcls_pkg::NUM_W-1:0]   cfg_wr_data,
    // Request channel.
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         restart,
    // Result channel.
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [dcls_pkg::NUM_W-1:0]   number,
    output logic      [dcls_pkg::COUNT_W-1:0] divisor_count,
    output logic                              is_prime,
    output logic                              at_limit,
    output logic                              exhausted
);

    import dcls_pkg::*;

    localparam int SV_DEPTH = MAX_VALUE + 1;
    localparam int SA_W     = $clog2(SV_DEPTH);
    localparam int PL_W     = $clog2(PRIME_CAPACITY);
    localparam int CNT_W    = $clog2(PRIME_CAPACITY + 1);
    localparam int ENTRY_W  = $bits(sieve_entry_t);
    localparam int unsigned LIM_CAP = (MAX_VALUE > NUM_MAX) ? NUM_MAX : MAX_VALUE;
    localparam logic [NUM_W-1:0] LIM_MAX   = NUM_W'(LIM_CAP);
    localparam logic [CNT_W-1:0] PL_FULL   = CNT_W'(PRIME_CAPACITY);
    localparam logic [SA_W-1:0]  CLR_LAST  = SA_W'(SV_DEPTH - 1);

    // Control state.
    seq_state_t       state_reg, state_next;
    logic [NUM_W-1:0] limit_reg;
    logic [NUM_W-1:0] cur_num_reg;
    logic [CNT_W-1:0] pcnt_reg;
    logic [CNT_W-1:0] k_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic             suspect_reg;
    logic             clr_item_reg;
    logic [SA_W-1:0]  clr_addr_reg;
    logic             pl_fwd_reg;
    logic             out_valid_reg;

    // Per-item payload.
    logic [NUM_W-1:0]   i_reg;
    logic               exh_reg;
    logic               prime_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] part_i_reg;
    logic [EXP_W-1:0]   exp_i_reg;
    logic [NUM_W-1:0]   spf_reg;
    logic [NUM_W-1:0]   p_reg;
    logic [2*NUM_W-1:0] q_reg;
    logic [NUM_W-1:0]   pl_fwd_data_reg;

    // Output word.
    logic [NUM_W-1:0]   number_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic               prime_out_reg;
    logic               at_limit_reg;
    logic               exh_out_reg;

    // Memory ports.
    logic               sv_wr_en;
    logic [SA_W-1:0]    sv_wr_addr;
    sieve_entry_t       sv_wr_data;
    logic               sv_rd_en;
    logic [SA_W-1:0]    sv_rd_addr;
    sieve_entry_t       sv_rd_data;
    logic               pl_wr_en;
    logic [PL_W-1:0]    pl_wr_addr;
    logic               pl_rd_en;
    logic [PL_W-1:0]    pl_rd_addr;
    logic [NUM_W-1:0]   pl_rd_data;

    rem_status_t        rem_st;
    logic               rem_start;

    // Combinational helpers.
    logic [NUM_W-1:0]   lim;
    logic               accept;
    logic               out_fire;
    logic [NUM_W-1:0]   cur_base;
    logic               exh_now;
    logic [NUM_W-1:0]   i_new;
    logic               epoch_wrap;
    logic               chk_prime;
    logic [COUNT_W-1:0] chk_part;
    logic [EXP_W-1:0]   chk_exp;
    logic [NUM_W-1:0]   chk_spf;
    logic               chk_append;
    logic [CNT_W-1:0]   chk_cnt;
    logic [NUM_W-1:0]   p_cur;
    logic               q_ok;
    logic               divides;
    logic               entry_wr;
    logic               walk_last;
    logic [EXP_W-1:0]   exp_inc;
    logic               finish_go;

    // Effective limit: the register clamped to the supported range.
    always_comb
    begin
        if (limit_reg < LIMIT_MIN)
            lim = LIMIT_MIN;
        else if (limit_reg > LIM_MAX)
            lim = LIM_MAX;
        else
            lim = limit_reg;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_fire   = out_valid_reg && out_ready;
    assign finish_go  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // Request decode: where the count continues from and what number comes next.
    assign cur_base   = restart ? '0 : cur_num_reg;
    assign exh_now    = (cur_base >= lim);
    assign i_new      = cur_base + 1'b1;
    assign epoch_wrap = restart && (epoch_reg == EPOCH_LAST);

    // Check of the entry read for the new number; an untagged entry is a prime.
    always_comb
    begin
        chk_prime  = (sv_rd_data.epoch != epoch_reg);
        chk_part   = chk_prime ? PRIME_PART : sv_rd_data.part;
        chk_exp    = chk_prime ? PRIME_EXP : sv_rd_data.exp1;
        chk_spf    = chk_prime ? i_reg : sv_rd_data.spf;
        chk_append = chk_prime && (pcnt_reg < PL_FULL);
        chk_cnt    = pcnt_reg + CNT_W'(chk_append);
    end

    // Prime walk: the multiple, the stop test and the write of the multiple's entry.
    assign p_cur     = pl_fwd_reg ? pl_fwd_data_reg : pl_rd_data;
    assign q_ok      = (q_reg <= {{NUM_W{1'b0}}, lim});
    assign divides   = (state_reg == ST_WALK_DIV) ? rem_st.divisible : (p_reg == spf_reg);
    assign entry_wr  = ((state_reg == ST_WALK_WR) && q_ok && !suspect_reg) ||
                       ((state_reg == ST_WALK_DIV) && rem_st.done);
    assign walk_last = divides || ((k_reg + 1'b1) == pcnt_reg);
    assign exp_inc   = (exp_i_reg == EXP_MAX) ? EXP_MAX : exp_i_reg + 1'b1;
    assign rem_start = (state_reg == ST_WALK_WR) && q_ok && suspect_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (exh_now)
                        state_next = ST_FINISH;
                    else if (i_new == NUM_W'(1))
                        state_next = epoch_wrap ? ST_CLEAR : ST_FINISH;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
                state_next = (chk_cnt == '0) ? ST_FINISH : ST_WALK_MUL;
            ST_WALK_MUL:
                state_next = ST_WALK_WR;
            ST_WALK_WR:
            begin
                if (!q_ok)
                    state_next = ST_FINISH;
                else if (suspect_reg)
                    state_next = ST_WALK_DIV;
                else
                    state_next = walk_last ? ST_FINISH : ST_WALK_MUL;
            end
            ST_WALK_DIV:
            begin
                if (rem_st.done)
                    state_next = walk_last ? ST_FINISH : ST_WALK_MUL;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (clr_addr_reg == CLR_LAST)
                    state_next = clr_item_reg ? ST_FINISH : ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sieve store ports: the clearing sweep owns the write port while it runs.
    always_comb
    begin
        sv_rd_en   = accept;
        sv_rd_addr = SA_W'(i_new);
        if (state_reg == ST_CLEAR)
        begin
            sv_wr_en         = 1'b1;
            sv_wr_addr       = clr_addr_reg;
            sv_wr_data       = '0;
            sv_wr_data.epoch = EPOCH_NONE;
        end
        else
        begin
            sv_wr_en         = entry_wr;
            sv_wr_addr       = SA_W'(q_reg);
            sv_wr_data.epoch = epoch_reg;
            sv_wr_data.spf   = p_reg;
            sv_wr_data.part  = divides ? part_i_reg : count_reg;
            sv_wr_data.exp1  = divides ? exp_inc : PRIME_EXP;
        end
    end

    // Prime list ports: append in the check cycle, read the next prime to walk.
    always_comb
    begin
        pl_wr_en   = (state_reg == ST_CHECK) && chk_append;
        pl_wr_addr = pcnt_reg[PL_W-1:0];
        pl_rd_en   = ((state_reg == ST_CHECK) && (chk_cnt != '0)) ||
                     (entry_wr && !walk_last);
        pl_rd_addr = (state_reg == ST_CHECK) ? '0 : PL_W'(k_reg + 1'b1);
    end

    dcls_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SV_DEPTH)
    ) u_sieve_ram (
        .clk     (clk),
        .wr_en   (sv_wr_en),
        .wr_addr (sv_wr_addr),
        .wr_data (sv_wr_data),
        .rd_en   (sv_rd_en),
        .rd_addr (sv_rd_addr),
        .rd_data (sv_rd_data)
    );

    dcls_ram #(
        .WIDTH (NUM_W),
        .DEPTH (PRIME_CAPACITY)
    ) u_prime_ram (
        .clk     (clk),
        .wr_en   (pl_wr_en),
        .wr_addr (pl_wr_addr),
        .wr_data (i_reg),
        .rd_en   (pl_rd_en),
        .rd_addr (pl_rd_addr),
        .rd_data (pl_rd_data)
    );

    dcls_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (i_reg),
        .divisor  (p_reg),
        .status   (rem_st)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            limit_reg     <= LIMIT_RESET;
            cur_num_reg   <= '0;
            pcnt_reg      <= '0;
            k_reg         <= '0;
            epoch_reg     <= EPOCH_FIRST;
            suspect_reg   <= 1'b0;
            clr_item_reg  <= 1'b0;
            clr_addr_reg  <= '0;
            pl_fwd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;

            // A limit change mid-run makes the stored factor data untrustworthy.
            if (accept && restart)
                suspect_reg <= 1'b0;
            else if (cfg_wr_en && (cur_num_reg != '0))
                suspect_reg <= 1'b1;

            // Request acceptance: restart opens a new epoch of composite tags.
            if (accept)
            begin
                if (!exh_now)
                    cur_num_reg <= i_new;
                if (restart)
                begin
                    pcnt_reg     <= '0;
                    epoch_reg    <= epoch_wrap ? EPOCH_FIRST : epoch_reg + 1'b1;
                    clr_item_reg <= epoch_wrap;
                    clr_addr_reg <= '0;
                end
            end

            // Clearing sweep.
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST)
                    clr_item_reg <= 1'b0;
            end

            // Prime count and walk index.
            if (state_reg == ST_CHECK)
            begin
                pcnt_reg <= chk_cnt;
                k_reg    <= '0;
            end
            else if (entry_wr && !walk_last)
                k_reg <= k_reg + 1'b1;

            // Forward a prime appended at the address being read in the same cycle.
            pl_fwd_reg <= pl_wr_en && pl_rd_en && (pl_wr_addr == pl_rd_addr);

            // Output handshake.
            if (finish_go)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            i_reg     <= i_new;
            exh_reg   <= exh_now;
            prime_reg <= 1'b0;
            count_reg <= ONE_COUNT;
        end

        if (state_reg == ST_CHECK)
        begin
            prime_reg  <= chk_prime;
            part_i_reg <= chk_part;
            exp_i_reg  <= chk_exp;
            spf_reg    <= chk_spf;
            count_reg  <= sat_count(chk_part, chk_exp);
        end

        pl_fwd_data_reg <= i_reg;

        // Multiple of the current number by the prime just read.
        if (state_reg == ST_WALK_MUL)
        begin
            p_reg <= p_cur;
            q_reg <= i_reg * p_cur;
        end

        if (finish_go)
        begin
            number_reg    <= exh_reg ? '0 : i_reg;
            count_out_reg <= exh_reg ? '0 : count_reg;
            prime_out_reg <= !exh_reg && prime_reg;
            at_limit_reg  <= !exh_reg && (i_reg == lim);
            exh_out_reg   <= exh_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign number        = number_reg;
    assign divisor_count = count_out_reg;
    assign is_prime      = prime_out_reg;
    assign at_limit      = at_limit_reg;
    assign exhausted     = exh_out_reg;

    // A multiple's entry is only written within the limit.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_wr_en && (state_reg != ST_CLEAR)) |-> (q_reg <= {{NUM_W{1'b0}}, lim}))
        else $error("sieve entry written beyond the limit");

    // The walk never reads past the filled part of the prime list.
    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK_MUL) |-> (k_reg < pcnt_reg))
        else $error("prime walk index beyond prime count");

    // The prime count stays within the list capacity.
    a_pcnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= PL_FULL)
        else $error("prime count exceeds capacity");

    // A restart always reports number one next.
    a_restart_one: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart) |=> (cur_num_reg == NUM_W'(1)))
        else $error("restart did not resume at one");

    // Outside the sweep the live epoch never equals the cleared tag.
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |-> (epoch_reg != EPOCH_NONE))
        else $error("live epoch equals the cleared tag");

endmodule

`default_nettype wire
